/* hw/rtl/kfcv_pkg.sv */
// Shared types, constants and helpers for the constant-velocity Kalman filter.
`timescale 1ns / 1ps
package kfcv_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int DIM = 6;
	localparam int AW = 8;
	localparam int MEM_DEPTH = 216;

	// Matrix store layout, row major; the inverse work area is 6 x 12.
	localparam logic [AW-1:0] BASE_PPOST = 8'd0;
	localparam logic [AW-1:0] BASE_PPRED = 8'd36;
	localparam logic [AW-1:0] BASE_TMP   = 8'd72;
	localparam logic [AW-1:0] BASE_GAIN  = 8'd108;
	localparam logic [AW-1:0] BASE_AUG   = 8'd144;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_Q_SCALE   = 2'd1;
	localparam logic [1:0] REG_R_SCALE   = 2'd2;

	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_PREDICT = 2'd1;
	localparam logic [1:0] FUNC_UPDATE  = 2'd2;

	typedef enum logic [3:0] {
		PH_PST,    // predicted state = A x
		PH_PAP,    // T = A P
		PH_PAPA,   // P- = T A^T + Q
		PH_SCPY,   // augmented [P- + R | I]
		PH_GJDIV,  // pivot row scaling
		PH_GJEL,   // row elimination
		PH_GAIN,   // K = P- inv(S)
		PH_XUPD,   // x = x- + K y
		PH_PUPD    // P = (I - K) P-
	} phase_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} in_word_t;

	typedef struct packed {
		logic               is_prediction;
		logic signed [31:0] est_pos_x;
		logic signed [31:0] est_pos_y;
		logic signed [31:0] est_pos_z;
		logic signed [31:0] est_vel_x;
		logic signed [31:0] est_vel_y;
		logic signed [31:0] est_vel_z;
	} out_word_t;

	typedef struct packed {
		phase_t          phase;
		logic [2:0]      i;
		logic [3:0]      j;
		logic [2:0]      k;
		logic            rd_en;
		logic [AW-1:0]   addr_a;
		logic [AW-1:0]   addr_b;
		logic            lat_scal;
		logic            mul_en;
		logic            acc_en;
		logic            wr_en;
		logic [AW-1:0]   wr_addr;
		logic            div_start;
		logic            accept;
		logic            out_load;
		logic            out_pred;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* hw/rtl/kfcv_div.sv */
// Radix-2 restoring fixed-point divider, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps
module kfcv_div
	import kfcv_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               busy,
	output logic signed [31:0] q
);
	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] num_q;
	logic [31:0]   den_q;
	logic [31:0]   rem_q;
	logic          neg_q;
	logic          zero_q;
	logic          apos_q;
	logic [32:0]   rem_sh;
	logic          qbit;
	logic [31:0]   mag_a;
	logic [31:0]   mag_b;

	assign mag_a  = a[31] ? 32'(-a) : 32'(a);
	assign mag_b  = b[31] ? 32'(-b) : 32'(b);
	assign rem_sh = {rem_q, num_q[DW-1]};
	assign qbit   = rem_sh >= {1'b0, den_q};
	assign busy   = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= (b == 32'sd0) ? '0 : CW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {mag_a, FRAC_BITS'(0)};
			den_q  <= mag_b;
			rem_q  <= '0;
			neg_q  <= a[31] ^ b[31];
			zero_q <= b == 32'sd0;
			apos_q <= !a[31];
		end else if (busy) begin
			rem_q <= qbit ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			num_q <= {num_q[DW-2:0], qbit};
		end
	end

	always_comb begin
		if (zero_q)
			q = apos_q ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		else if (neg_q)
			q = (num_q > DW'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-num_q);
		else
			q = (num_q > DW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : num_q[31:0];
	end

endmodule

/* hw/rtl/kfcv_dpath.sv */
// Datapath: matrix store, state vectors, shared multiply-accumulate, divider, output word.
`timescale 1ns / 1ps
module kfcv_dpath
	import kfcv_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  in_word_t    in_data,
	input  logic [20:0] time_step,
	input  logic [30:0] q_scale,
	input  logic [30:0] r_scale,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);
	localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [31:0] mem_q [MEM_DEPTH];
	logic signed [31:0] rda_q, rdb_q, scal_q;
	logic signed [31:0] post_state_q [DIM];
	logic signed [31:0] pred_state_q [DIM];
	logic signed [31:0] y_q [DIM];
	logic signed [63:0] prod_q, acc_q;
	logic               post_ident_q, pred_ident_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic signed [31:0] opa, opb, init_v, wdata, div_q, z [DIM];
	logic [30:0]        post_v;
	logic               sub_v, div_busy, vec_dest;
	logic signed [63:0] term;

	function automatic logic signed [31:0] a_elem(input logic [2:0] r, input logic [2:0] c,
		input logic [20:0] dt);
		logic signed [31:0] v;
		if (r == c)
			v = ONE;
		else if (r < 3'd3 && c == r + 3'd3)
			v = 32'(dt);
		else
			v = '0;
		return v;
	endfunction

	function automatic logic signed [31:0] eye(input logic [3:0] r, input logic [3:0] c);
		return (r == c) ? ONE : 32'sd0;
	endfunction

	kfcv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.a     (rda_q),
		.b     (scal_q),
		.busy  (div_busy),
		.q     (div_q)
	);

	assign z[0] = in_data.pos_x;
	assign z[1] = in_data.pos_y;
	assign z[2] = in_data.pos_z;
	assign z[3] = in_data.vel_x;
	assign z[4] = in_data.vel_y;
	assign z[5] = in_data.vel_z;

	always_comb begin
		opa    = '0;
		opb    = '0;
		init_v = '0;
		post_v = '0;
		sub_v  = 1'b0;
		unique case (cmd.phase)
			PH_PST: begin
				opa = a_elem(cmd.i, cmd.k, time_step);
				opb = post_state_q[cmd.k];
			end
			PH_PAP: begin
				opa = a_elem(cmd.i, cmd.k, time_step);
				opb = post_ident_q ? eye({1'b0, cmd.k}, cmd.j) : rdb_q;
			end
			PH_PAPA: begin
				opa = rda_q;
				opb = a_elem(cmd.j[2:0], cmd.k, time_step);
				post_v = ({1'b0, cmd.i} == cmd.j) ? q_scale : '0;
			end
			PH_SCPY: begin
				opb = ONE;
				if (cmd.j < 4'd6) begin
					opa = pred_ident_q ? eye({1'b0, cmd.i}, cmd.j) : rda_q;
					post_v = ({1'b0, cmd.i} == cmd.j) ? r_scale : '0;
				end else begin
					post_v = ({1'b0, cmd.i} + 4'd6 == cmd.j) ? ONE[30:0] : '0;
				end
			end
			PH_GJDIV: begin
				opa = '0;
			end
			PH_GJEL: begin
				opa    = scal_q;
				opb    = rda_q;
				init_v = rdb_q;
				sub_v  = 1'b1;
			end
			PH_GAIN: begin
				opa = pred_ident_q ? eye({1'b0, cmd.i}, {1'b0, cmd.k}) : rda_q;
				opb = rdb_q;
			end
			PH_XUPD: begin
				opa    = rda_q;
				opb    = y_q[cmd.k];
				init_v = pred_state_q[cmd.i];
			end
			PH_PUPD: begin
				opa = sat32(64'(eye({1'b0, cmd.i}, {1'b0, cmd.k})) - 64'(rda_q));
				opb = pred_ident_q ? eye({1'b0, cmd.k}, cmd.j) : rdb_q;
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	assign term     = (prod_q + HALF) >>> FRAC_BITS;
	assign wdata    = (cmd.phase == PH_GJDIV) ? div_q
		: sat32(64'(sat32(acc_q)) + {33'b0, post_v});
	assign vec_dest = cmd.phase == PH_PST || cmd.phase == PH_XUPD;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && !vec_dest)
			mem_q[cmd.wr_addr] <= wdata;
		if (cmd.rd_en) begin
			rda_q <= mem_q[cmd.addr_a];
			rdb_q <= mem_q[cmd.addr_b];
		end
		if (cmd.lat_scal)
			scal_q <= rdb_q;
		if (cmd.mul_en) begin
			prod_q <= 64'(opa) * 64'(opb);
			if (cmd.k == 3'd0)
				acc_q <= 64'(init_v);
		end else if (cmd.acc_en) begin
			acc_q <= sub_v ? acc_q - term : acc_q + term;
		end
		if (cmd.accept && in_data.func == FUNC_UPDATE) begin
			for (int n = 0; n < DIM; n++)
				y_q[n] <= sat32(64'(z[n]) - 64'(pred_state_q[n]));
		end
		if (cmd.out_load) begin
			out_q.is_prediction <= cmd.out_pred;
			out_q.est_pos_x <= cmd.out_pred ? pred_state_q[0] : post_state_q[0];
			out_q.est_pos_y <= cmd.out_pred ? pred_state_q[1] : post_state_q[1];
			out_q.est_pos_z <= cmd.out_pred ? pred_state_q[2] : post_state_q[2];
			out_q.est_vel_x <= cmd.out_pred ? pred_state_q[3] : post_state_q[3];
			out_q.est_vel_y <= cmd.out_pred ? pred_state_q[4] : post_state_q[4];
			out_q.est_vel_z <= cmd.out_pred ? pred_state_q[5] : post_state_q[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DIM; n++) begin
				post_state_q[n] <= '0;
				pred_state_q[n] <= '0;
			end
			post_ident_q <= 1'b1;
			pred_ident_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept && in_data.func == FUNC_LOAD) begin
				for (int n = 0; n < DIM; n++)
					post_state_q[n] <= z[n];
			end
			if (cmd.wr_en && cmd.phase == PH_PST)
				pred_state_q[cmd.i] <= wdata;
			if (cmd.wr_en && cmd.phase == PH_XUPD)
				post_state_q[cmd.i] <= wdata;
			if (cmd.wr_en && cmd.phase == PH_PUPD)
				post_ident_q <= 1'b0;
			if (cmd.wr_en && cmd.phase == PH_PAPA)
				pred_ident_q <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.div_done = !div_busy;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

/* hw/rtl/kfcv_ctrl.sv */
// Controller: item sequencing, loop counters and matrix store addressing.
`timescale 1ns / 1ps
module kfcv_ctrl
	import kfcv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  stat_t      stat,
	output cmd_t       cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_PRE   = 10'b00_0000_0010,
		S_LAT   = 10'b00_0000_0100,
		S_RD    = 10'b00_0000_1000,
		S_MUL   = 10'b00_0001_0000,
		S_ACC   = 10'b00_0010_0000,
		S_WR    = 10'b00_0100_0000,
		S_DIV   = 10'b00_1000_0000,
		S_DWAIT = 10'b01_0000_0000,
		S_FIN   = 10'b10_0000_0000
	} state_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [2:0] i_q, k_q, c_q;
	logic [3:0] j_q;
	logic       pending_q, pred_q;

	logic [2:0] nk;
	logic [3:0] nj, nxt_r;

	function automatic logic [AW-1:0] p_addr(input logic [AW-1:0] base, input logic [3:0] r,
		input logic [3:0] c);
		return base + AW'(r) * AW'(DIM) + AW'(c);
	endfunction

	function automatic logic [AW-1:0] m_addr(input logic [3:0] r, input logic [3:0] c);
		return BASE_AUG + AW'(r) * AW'(2 * DIM) + AW'(c);
	endfunction

	always_comb begin
		unique case (phase_q)
			PH_SCPY, PH_GJDIV, PH_GJEL: nk = 3'd1;
			default:                    nk = 3'd6;
		endcase
		unique case (phase_q)
			PH_PST, PH_XUPD:            nj = 4'd1;
			PH_SCPY, PH_GJDIV, PH_GJEL: nj = 4'd12;
			default:                    nj = 4'd6;
		endcase
		nxt_r = {1'b0, i_q} + 4'd1;
		if (nxt_r == {1'b0, c_q})
			nxt_r = nxt_r + 4'd1;
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		logic [3:0] ii, jj, kk, cc;
		ii = {1'b0, i_q};
		jj = j_q;
		kk = {1'b0, k_q};
		cc = {1'b0, c_q};
		cmd = '0;
		cmd.phase = phase_q;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.k = k_q;
		cmd.out_pred = pred_q;
		unique case (phase_q)
			PH_PAP:   cmd.addr_b = p_addr(BASE_PPOST, kk, jj);
			PH_PAPA:  cmd.addr_a = p_addr(BASE_TMP, ii, kk);
			PH_SCPY:  cmd.addr_a = p_addr(BASE_PPRED, ii, (jj < 4'd6) ? jj : 4'd0);
			PH_GJDIV: begin
				cmd.addr_a = m_addr(cc, jj);
				cmd.addr_b = m_addr(cc, cc);
			end
			PH_GJEL: begin
				cmd.addr_a = m_addr(cc, jj);
				cmd.addr_b = (state_q == S_PRE) ? m_addr(ii, cc) : m_addr(ii, jj);
			end
			PH_GAIN: begin
				cmd.addr_a = p_addr(BASE_PPRED, ii, kk);
				cmd.addr_b = m_addr(kk, jj + 4'd6);
			end
			PH_XUPD:  cmd.addr_a = p_addr(BASE_GAIN, ii, kk);
			PH_PUPD: begin
				cmd.addr_a = p_addr(BASE_GAIN, ii, kk);
				cmd.addr_b = p_addr(BASE_PPRED, kk, jj);
			end
			default:  cmd.addr_a = '0;
		endcase
		unique case (phase_q)
			PH_PAP:           cmd.wr_addr = p_addr(BASE_TMP, ii, jj);
			PH_PAPA:          cmd.wr_addr = p_addr(BASE_PPRED, ii, jj);
			PH_SCPY, PH_GJEL: cmd.wr_addr = m_addr(ii, jj);
			PH_GJDIV:         cmd.wr_addr = m_addr(cc, jj);
			PH_GAIN:          cmd.wr_addr = p_addr(BASE_GAIN, ii, jj);
			PH_PUPD:          cmd.wr_addr = p_addr(BASE_PPOST, ii, jj);
			default:          cmd.wr_addr = '0;
		endcase
		unique case (state_q)
			S_IDLE:  cmd.accept = in_valid;
			S_PRE:   cmd.rd_en = 1'b1;
			S_LAT:   cmd.lat_scal = 1'b1;
			S_RD:    cmd.rd_en = 1'b1;
			S_MUL:   cmd.mul_en = 1'b1;
			S_ACC:   cmd.acc_en = 1'b1;
			S_WR:    cmd.wr_en = 1'b1;
			S_DIV:   cmd.div_start = 1'b1;
			S_DWAIT: cmd.rd_en = 1'b0;
			S_FIN:   cmd.out_load = stat.out_free;
			default: cmd.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_PST;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			c_q       <= '0;
			pending_q <= 1'b0;
			pred_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						c_q <= '0;
						pred_q <= func == FUNC_PREDICT;
						state_q <= S_FIN;
						if (func == FUNC_PREDICT && !pending_q) begin
							phase_q <= PH_PST;
							state_q <= S_RD;
						end else if (func == FUNC_UPDATE) begin
							phase_q <= PH_SCPY;
							state_q <= S_RD;
						end
					end
				end
				S_PRE: state_q <= S_LAT;
				S_LAT: state_q <= S_RD;
				S_RD:  state_q <= (phase_q == PH_GJDIV) ? S_DIV : S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (k_q == nk - 3'd1) begin
						state_q <= S_WR;
					end else begin
						k_q <= k_q + 3'd1;
						state_q <= S_RD;
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (stat.div_done)
						state_q <= S_WR;
				end
				S_WR: begin
					k_q <= '0;
					if (j_q != nj - 4'd1) begin
						j_q <= j_q + 4'd1;
						state_q <= S_RD;
					end else begin
						j_q <= '0;
						priority case (phase_q)
							PH_GJDIV: begin
								phase_q <= PH_GJEL;
								i_q <= (c_q == 3'd0) ? 3'd1 : 3'd0;
								state_q <= S_PRE;
							end
							PH_GJEL: begin
								if (nxt_r < 4'd6) begin
									i_q <= nxt_r[2:0];
									state_q <= S_PRE;
								end else if (c_q != 3'd5) begin
									c_q <= c_q + 3'd1;
									i_q <= c_q + 3'd1;
									phase_q <= PH_GJDIV;
									state_q <= S_PRE;
								end else begin
									i_q <= '0;
									phase_q <= PH_GAIN;
									state_q <= S_RD;
								end
							end
							default: begin
								if (i_q != 3'd5) begin
									i_q <= i_q + 3'd1;
									state_q <= S_RD;
								end else begin
									i_q <= '0;
									state_q <= S_RD;
									priority case (phase_q)
										PH_PST:  phase_q <= PH_PAP;
										PH_PAP:  phase_q <= PH_PAPA;
										PH_PAPA: begin
											pending_q <= 1'b1;
											state_q <= S_FIN;
										end
										PH_SCPY: begin
											phase_q <= PH_GJDIV;
											c_q <= '0;
											state_q <= S_PRE;
										end
										PH_GAIN: phase_q <= PH_XUPD;
										PH_XUPD: phase_q <= PH_PUPD;
										default: begin
											pending_q <= 1'b0;
											state_q <= S_FIN;
										end
									endcase
								end
							end
						endcase
					end
				end
				S_FIN: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/kalman_filter_const_velocity.sv */
// Work per word: load, unused code and repeated predict go straight to the output stage;
// predict does 6 + 36 + 36 dot products on the shared multiply-accumulate, each term
// through read, multiply and accumulate states; update does 72 serial divisions, 360
// row-elimination steps, 36 + 6 + 36 dot products and a 72-entry augmented-matrix copy.
// Throughput: one word at a time, taken once the previous result is in the output register.
// Reset: asynchronous; state vectors zero, covariances identity, dt 0, q 0.1, r 10.
`timescale 1ns / 1ps
module kalman_filter_const_velocity
	import kfcv_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [30:0] cfg_wdata
);
	localparam logic [30:0] Q_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [30:0] R_RESET = 31'((64'd1 << FRAC_BITS) * 64'd10);

	logic [20:0] time_step_q;
	logic [30:0] q_scale_q, r_scale_q;
	cmd_t        cmd;
	stat_t       stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			q_scale_q   <= Q_RESET;
			r_scale_q   <= R_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TIME_STEP: time_step_q <= cfg_wdata[20:0];
				REG_Q_SCALE:   q_scale_q   <= cfg_wdata;
				REG_R_SCALE:   r_scale_q   <= cfg_wdata;
				default:       time_step_q <= time_step_q;
			endcase
		end
	end

	kfcv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func    (in_data.func),
		.stat    (stat),
		.cmd     (cmd)
	);

	kfcv_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.time_step(time_step_q),
		.q_scale  (q_scale_q),
		.r_scale  (r_scale_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

/* tb/sv/kfcv_checker.sv */
// Checker for the constant-velocity Kalman filter: predicts each output word and compares.
`timescale 1ns / 1ps
module kfcv_checker
	import kfcv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [30:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	localparam int FB = DEF_FRAC_BITS;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FB;

	typedef logic signed [31:0] vec_t [6];
	typedef logic signed [31:0] mat_t [36];

	vec_t x_post, x_pred;
	mat_t p_post, p_pred;
	logic pend;
	logic [20:0] dt;
	logic [30:0] qs, rs;
	out_word_t est_q[$];

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] fmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + (64'sd1 <<< (FB - 1));
		return p >>> FB;
	endfunction

	function automatic logic signed [31:0] fdiv(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] n;
		if (b == 0) return a >= 0 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		n = 64'(a) <<< FB;
		return sat(n / 64'(b));
	endfunction

	function automatic mat_t mmul(input mat_t a, input mat_t b, input bit tb);
		mat_t t;
		logic signed [63:0] acc;
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 6; j++) begin
				acc = 0;
				for (int k = 0; k < 6; k++)
					acc += fmul(a[i*6+k], tb ? b[j*6+k] : b[k*6+j]);
				t[i*6+j] = sat(acc);
			end
		return t;
	endfunction

	function automatic mat_t minv(input mat_t s);
		logic signed [31:0] m [6][12];
		logic signed [31:0] pv, f;
		mat_t o;
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 6; j++) begin
				m[i][j] = s[i*6+j];
				m[i][6+j] = (i == j) ? ONE : 0;
			end
		for (int c = 0; c < 6; c++) begin
			pv = m[c][c];
			for (int j = 0; j < 12; j++) m[c][j] = fdiv(m[c][j], pv);
			for (int r = 0; r < 6; r++)
				if (r != c) begin
					f = m[r][c];
					for (int j = 0; j < 12; j++)
						m[r][j] = sat(64'(m[r][j]) - fmul(f, m[c][j]));
				end
		end
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 6; j++) o[i*6+j] = m[i][6+j];
		return o;
	endfunction

	task automatic run_predict();
		mat_t a, t;
		logic signed [63:0] acc;
		if (pend) return;
		for (int i = 0; i < 36; i++) a[i] = (i % 7 == 0) ? ONE : 0;
		for (int i = 0; i < 3; i++) a[i*6+i+3] = {11'd0, dt};
		for (int i = 0; i < 6; i++) begin
			acc = 0;
			for (int k = 0; k < 6; k++) acc += fmul(a[i*6+k], x_post[k]);
			x_pred[i] = sat(acc);
		end
		t = mmul(a, p_post, 0);
		t = mmul(t, a, 1);
		for (int i = 0; i < 6; i++) t[i*7] = sat(64'(t[i*7]) + 64'({1'b0, qs}));
		p_pred = t;
		pend = 1;
	endtask

	task automatic run_update(input vec_t z);
		mat_t s, k;
		vec_t y;
		logic signed [63:0] acc;
		s = p_pred;
		for (int i = 0; i < 6; i++) s[i*7] = sat(64'(s[i*7]) + 64'({1'b0, rs}));
		s = minv(s);
		k = mmul(p_pred, s, 0);
		for (int i = 0; i < 6; i++) y[i] = sat(64'(z[i]) - 64'(x_pred[i]));
		for (int i = 0; i < 6; i++) begin
			acc = 64'(x_pred[i]);
			for (int j = 0; j < 6; j++) acc += fmul(k[i*6+j], y[j]);
			x_post[i] = sat(acc);
		end
		for (int i = 0; i < 36; i++)
			k[i] = sat(((i % 7 == 0) ? 64'(ONE) : 64'sd0) - 64'(k[i]));
		p_post = mmul(k, p_pred, 0);
		pend = 0;
	endtask

	task automatic take_word(input in_word_t w);
		vec_t v;
		out_word_t e;
		v = '{w.pos_x, w.pos_y, w.pos_z, w.vel_x, w.vel_y, w.vel_z};
		e.is_prediction = 0;
		case (w.func)
			FUNC_LOAD: x_post = v;
			FUNC_PREDICT: begin
				run_predict();
				e.is_prediction = 1;
			end
			FUNC_UPDATE: run_update(v);
			default: ;
		endcase
		if (e.is_prediction)
			{e.est_pos_x, e.est_pos_y, e.est_pos_z, e.est_vel_x, e.est_vel_y, e.est_vel_z} =
				{x_pred[0], x_pred[1], x_pred[2], x_pred[3], x_pred[4], x_pred[5]};
		else
			{e.est_pos_x, e.est_pos_y, e.est_pos_z, e.est_vel_x, e.est_vel_y, e.est_vel_z} =
				{x_post[0], x_post[1], x_post[2], x_post[3], x_post[4], x_post[5]};
		est_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				x_post[i] <= 0;
				x_pred[i] <= 0;
			end
			for (int i = 0; i < 36; i++) begin
				p_post[i] <= (i % 7 == 0) ? ONE : 0;
				p_pred[i] <= (i % 7 == 0) ? ONE : 0;
			end
			pend <= 0;
			dt <= 0;
			qs <= 31'd6554;
			rs <= 31'd655360;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (est_q.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					if (est_q[0] !== out_data) begin
						$display("%0t: mismatch expected %h actual %h", $time, est_q[0], out_data);
						fail_count <= fail_count + 1;
					end
					void'(est_q.pop_front());
				end
			end
			if (cfg_we)
				case (cfg_idx)
					REG_TIME_STEP: dt = cfg_wdata[20:0];
					REG_Q_SCALE:   qs = cfg_wdata;
					REG_R_SCALE:   rs = cfg_wdata;
					default: ;
				endcase
			if (in_valid && in_ready) take_word(in_data);
			pending <= est_q.size();
		end
	end

endmodule

/* tb/sv/tb_kalman_filter_const_velocity.sv */
// Testbench top for the constant-velocity Kalman filter: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_kalman_filter_const_velocity;
	import kfcv_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_word_t out_data;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = REG_TIME_STEP;
	logic [30:0] cfg_wdata = '0;
	int fail_count, pending;
	int cycles = 0;
	bit calm = 0;
	int out_gap = 0;

	localparam int LIMIT = 30_000_000;

	kalman_filter_const_velocity dut (.*);

	kfcv_checker chk (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[kalman_filter_const_velocity] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (calm) out_ready <= 1;
		else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 0;
		end else if ($urandom_range(7) == 0) begin
			out_gap <= $urandom_range(15, 0);
			out_ready <= 0;
		end else out_ready <= 1;
	end

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(40 << 16)) - (20 << 16);
		endcase
	endfunction

	task automatic send(input logic [1:0] f, input logic signed [31:0] v [6]);
		in_word_t w;
		if (!calm && $urandom_range(3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
		w.func = f;
		{w.pos_x, w.pos_y, w.pos_z, w.vel_x, w.vel_y, w.vel_z} =
			{v[0], v[1], v[2], v[3], v[4], v[5]};
		in_data <= w;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_rand(input logic [1:0] f);
		logic signed [31:0] v [6];
		foreach (v[i]) v[i] = rand_val();
		send(f, v);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		logic signed [31:0] v [6];
		logic [1:0] f;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_rand(FUNC_UPDATE);
		send_rand(FUNC_PREDICT);
		send_rand(FUNC_PREDICT);
		foreach (v[i]) v[i] = 32'sh7FFF_FFFF;
		send(FUNC_LOAD, v);
		send(2'd3, v);
		foreach (v[i]) v[i] = 32'sh8000_0000;
		send(FUNC_UPDATE, v);
		write_reg(REG_TIME_STEP, 31'd1048576);
		write_reg(REG_Q_SCALE, 31'h7FFF_FFFF);
		write_reg(REG_R_SCALE, 31'd1);
		send(FUNC_LOAD, v);
		send_rand(FUNC_PREDICT);
		send_rand(FUNC_UPDATE);
		write_reg(REG_Q_SCALE, 31'd0);
		write_reg(REG_R_SCALE, 31'h7FFF_FFFF);
		send_rand(FUNC_PREDICT);
		send_rand(FUNC_UPDATE);
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_TIME_STEP, ph == 0 ? 31'd0 : 31'($urandom_range(1048576)));
			write_reg(REG_Q_SCALE, 31'($urandom_range(1 << 18)));
			write_reg(REG_R_SCALE, ph == 1 ? 31'd1 : 31'($urandom_range(1 << 22, 1)));
			if (ph == 5) calm = 1;
			for (int n = 0; n < 50; n++) begin
				case ($urandom_range(9))
					0: f = 2'($urandom);
					1, 2: f = FUNC_LOAD;
					3, 4, 5: f = FUNC_PREDICT;
					default: f = FUNC_UPDATE;
				endcase
				send_rand(f);
			end
		end
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[kalman_filter_const_velocity] OK");
		else
			$display("[kalman_filter_const_velocity] ERROR");
		$finish;
	end

endmodule
